[rtl/pip_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// Shared constants and types for the point-in-polygon gate.
// ----------------------------------------------------------------------------
package pip_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int COORD_BITS   = 16;
   localparam int ADDR_BITS    = 6;
   localparam int COUNT_BITS   = 7;
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int PROD_BITS    = 2 * DIFF_BITS;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_TEST = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [ADDR_BITS-1:0]  addr_type;
   typedef logic        [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } vertex_type;

endpackage

[rtl/pip_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_req_if
// Request channel: vertex load or point test word.
// ----------------------------------------------------------------------------
interface pip_req_if;
   logic                valid;
   logic                ready;
   logic                action;
   pip_pkg::addr_type   vertex_index;
   pip_pkg::coord_type  x_coord;
   pip_pkg::coord_type  y_coord;

   modport source (output valid, output action, output vertex_index,
                   output x_coord, output y_coord, input ready);
   modport sink   (input valid, input action, input vertex_index,
                   input x_coord, input y_coord, output ready);
endinterface

[rtl/pip_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_rsp_if
// Response channel: one inside flag per test word.
// ----------------------------------------------------------------------------
interface pip_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, output inside_res, input ready);
   modport sink   (input valid, input inside_res, output ready);
endinterface

[rtl/pip_csr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_csr_if
// Register write channel: vertex count.
// ----------------------------------------------------------------------------
interface pip_csr_if;
   logic                valid;
   logic                ready;
   pip_pkg::count_type  vertex_count;

   modport source (output valid, output vertex_count, input ready);
   modport sink   (input valid, input vertex_count, output ready);
endinterface

[rtl/point_in_polygon_gate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_gate
// Even-odd ray crossing test of a point against a stored polygon.
// ----------------------------------------------------------------------------
// A load word writes one vertex into the 64-entry vertex memory. A test word
// walks the vertex memory one entry per cycle through its single read port
// for the n vertices in use (clamped to 64): n reads, one stage for the two
// cross-product multiplies, one for compare and accumulate, and one to load
// the response register. With fewer than two vertices the answer is outside.
// Requests are taken while the engine is idle, even if a response still
// waits.
// ----------------------------------------------------------------------------
module point_in_polygon_gate (
   input  logic        clock,
   input  logic        reset,
   pip_req_if.sink     req_bus,
   pip_rsp_if.source   rsp_bus,
   pip_csr_if.sink     csr_bus
);

   typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_WAIT, ST_HOLD} state_type;

   state_type                          state_ff;
   pip_pkg::count_type                 count_ff;
   pip_pkg::addr_type                  last_ff;
   pip_pkg::addr_type                  addr_ff;
   pip_pkg::coord_type                 px_ff;
   pip_pkg::coord_type                 py_ff;

   pip_pkg::vertex_type                vtx_mem [pip_pkg::MAX_VERTICES];
   pip_pkg::vertex_type                rd_data_ff;
   logic                               rd_valid_ff;
   logic                               rd_first_ff;
   logic                               rd_last_ff;
   pip_pkg::vertex_type                prev_ff;

   logic                               e_valid_ff;
   logic                               e_last_ff;
   logic                               e_vhit_ff;
   logic                               e_cross_ff;
   logic                               e_dir_ff;
   logic signed [pip_pkg::PROD_BITS-1:0] p_ff;
   logic signed [pip_pkg::PROD_BITS-1:0] q_ff;

   logic                               hit_ff;
   logic                               odd_ff;
   logic                               res_ff;
   logic                               rsp_valid_ff;
   logic                               rsp_res_ff;

   logic                               req_accept;
   logic                               csr_accept;
   logic                               issue;
   pip_pkg::count_type                 n_eff;
   pip_pkg::addr_type                  last_in;
   logic signed [pip_pkg::DIFF_BITS-1:0] dx;
   logic signed [pip_pkg::DIFF_BITS-1:0] dy0;
   logic signed [pip_pkg::DIFF_BITS-1:0] dxv;
   logic signed [pip_pkg::DIFF_BITS-1:0] dy;
   logic signed [pip_pkg::PROD_BITS-1:0] p_in;
   logic signed [pip_pkg::PROD_BITS-1:0] q_in;
   logic                               vhit_in;
   logic                               cross_in;
   logic                               dir_in;
   logic                               prod_eq;
   logic                               prod_lt;
   logic                               hit_now;
   logic                               toggle;

   assign req_bus.ready  = (state_ff == ST_IDLE);
   assign csr_bus.ready  = 1'b1;
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.inside_res = rsp_res_ff;

   assign req_accept = req_bus.valid && req_bus.ready;
   assign csr_accept = csr_bus.valid && csr_bus.ready;
   assign issue      = (state_ff == ST_WALK);

   assign n_eff   = (count_ff > pip_pkg::COUNT_BITS'(pip_pkg::MAX_VERTICES)) ?
                    pip_pkg::COUNT_BITS'(pip_pkg::MAX_VERTICES) : count_ff;
   assign last_in = pip_pkg::ADDR_BITS'(n_eff - pip_pkg::COUNT_BITS'(1));

   // edge from prev_ff (vertex i) to rd_data_ff (vertex i+1)
   assign dx  = pip_pkg::DIFF_BITS'(px_ff)        - pip_pkg::DIFF_BITS'(rd_data_ff.x);
   assign dy0 = pip_pkg::DIFF_BITS'(prev_ff.y)    - pip_pkg::DIFF_BITS'(rd_data_ff.y);
   assign dxv = pip_pkg::DIFF_BITS'(prev_ff.x)    - pip_pkg::DIFF_BITS'(rd_data_ff.x);
   assign dy  = pip_pkg::DIFF_BITS'(py_ff)        - pip_pkg::DIFF_BITS'(rd_data_ff.y);
   assign p_in = pip_pkg::PROD_BITS'(dx)  * pip_pkg::PROD_BITS'(dy0);
   assign q_in = pip_pkg::PROD_BITS'(dxv) * pip_pkg::PROD_BITS'(dy);

   assign vhit_in  = (px_ff == rd_data_ff.x) && (py_ff == rd_data_ff.y);
   assign cross_in = (rd_data_ff.y > py_ff) != (prev_ff.y > py_ff);
   assign dir_in   = (prev_ff.y < rd_data_ff.y);

   assign prod_eq = (p_ff == q_ff);
   assign prod_lt = (p_ff < q_ff);
   assign hit_now = e_vhit_ff || (e_cross_ff && prod_eq);
   assign toggle  = e_cross_ff && !prod_eq && (prod_lt != e_dir_ff);

   // vertex memory
   always_ff @(posedge clock) begin
      if (req_accept && (req_bus.action == pip_pkg::ACT_LOAD)) begin
         vtx_mem[req_bus.vertex_index] <= '{x: req_bus.x_coord, y: req_bus.y_coord};
      end
      if (issue) begin
         rd_data_ff <= vtx_mem[addr_ff];
      end
   end

   // edge datapath
   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         prev_ff <= rd_data_ff;
      end
      p_ff       <= p_in;
      q_ff       <= q_in;
      e_vhit_ff  <= vhit_in;
      e_cross_ff <= cross_in;
      e_dir_ff   <= dir_in;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         e_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_accept) begin
            count_ff <= csr_bus.vertex_count;
         end

         rd_valid_ff <= issue;
         rd_first_ff <= (addr_ff == '0);
         rd_last_ff  <= (addr_ff == last_ff);
         e_valid_ff  <= rd_valid_ff && !rd_first_ff;
         e_last_ff   <= rd_last_ff;

         if (e_valid_ff) begin
            hit_ff <= hit_ff || hit_now;
            odd_ff <= odd_ff ^ toggle;
         end

         if (rsp_valid_ff && rsp_bus.ready && (state_ff != ST_HOLD)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_accept && (req_bus.action == pip_pkg::ACT_TEST)) begin
                  px_ff   <= req_bus.x_coord;
                  py_ff   <= req_bus.y_coord;
                  hit_ff  <= 1'b0;
                  odd_ff  <= 1'b0;
                  addr_ff <= '0;
                  last_ff <= last_in;
                  if (n_eff < pip_pkg::COUNT_BITS'(2)) begin
                     res_ff   <= 1'b0;
                     state_ff <= ST_HOLD;
                  end else begin
                     state_ff <= ST_WALK;
                  end
               end
            end
            ST_WALK: begin
               addr_ff <= addr_ff + pip_pkg::ADDR_BITS'(1);
               if (addr_ff == last_ff) begin
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (e_valid_ff && e_last_ff) begin
                  res_ff   <= hit_ff || hit_now || (odd_ff ^ toggle);
                  state_ff <= ST_HOLD;
               end
            end
            ST_HOLD: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_res_ff   <= res_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_rsp_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_HOLD))
      else $error("response raised outside hold state");

   a_edge_in_walk: assert property (@(posedge clock) disable iff (reset)
      e_valid_ff |-> (state_ff == ST_WALK || state_ff == ST_WAIT))
      else $error("edge result outside a walk");

   a_addr_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (addr_ff <= last_ff))
      else $error("vertex read past last vertex");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD && rsp_valid_ff && !rsp_bus.ready) |=> (state_ff == ST_HOLD))
      else $error("hold left while response stalled");
`endif

endmodule
